[sv/symplectic_motion_integrator_macros.svh]
// Assertion helpers for the symplectic motion integrator.
// Expanded inside modules that provide clk and arst_n.
`ifndef SYMPLECTIC_MOTION_INTEGRATOR_MACROS_SVH
`define SYMPLECTIC_MOTION_INTEGRATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SMI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SMI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/smi_pkg.sv]
// Shared types, constants and arithmetic helpers for the motion integrator.
// No dependencies; used by every module of the block.
`default_nettype none

package smi_pkg;

	localparam int WORD_W     = 32;                     // Q16.16 word
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = 20;                     // input step length
	localparam int COEF_W     = 17;                     // Forest-Ruth coefficients
	localparam int COEF_FRAC  = 16;
	localparam int MP_W       = STEP_W + COEF_W;        // step times coefficient
	localparam int DT_W       = 22;                     // signed substep length
	localparam int PROD_W     = WORD_W + DT_W;          // word times substep
	localparam int SUM_W      = PROD_W - FRAC_W + 1;
	localparam int LEVELS     = 6;                      // dependent update levels
	localparam int CAP        = 2 + 2 * LEVELS + 2;     // item slots in the block
	localparam int FLIGHT_W   = $clog2(CAP + 1);

	localparam logic [COEF_W-1:0] FR_OUTER = COEF_W'(88553);
	localparam logic [COEF_W-1:0] FR_INNER = COEF_W'(111569);

	localparam logic [1:0] MODE_EULER       = 2'd0;
	localparam logic [1:0] MODE_VERLET      = 2'd1;
	localparam logic [1:0] MODE_FOREST_RUTH = 2'd2;

	localparam logic REG_MODE = 1'b0;                  // register index bit of paddr

	typedef logic [2:0][WORD_W-1:0] vec3_t;

	typedef struct packed {
		vec3_t             pos;
		vec3_t             vel;
		vec3_t             acc;
		logic [1:0]        mode;
		logic [STEP_W-1:0] dt;
		logic [DT_W-1:0]   d1;   // outer Forest-Ruth substep
		logic [DT_W-1:0]   d2;   // inner Forest-Ruth substep, negative
	} body_t;

	typedef struct packed {
		vec3_t pos;
		vec3_t vel;
	} res_t;

	typedef struct packed {
		logic [DT_W-1:0] sp;     // step applied to the position update
		logic [DT_W-1:0] sv;     // step applied to the velocity update
	} steps_t;

	// x + (p >>> FRAC_W), clamped to a signed word
	function automatic logic [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] x,
		input logic signed [PROD_W-1:0] p);
		logic signed [SUM_W-1:0] s;
		logic [WORD_W-1:0]       r;
		s = SUM_W'(x) + SUM_W'(p >>> FRAC_W);
		if (!s[SUM_W-1] && (|s[SUM_W-2:WORD_W-1])) begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end else if (s[SUM_W-1] && !(&s[SUM_W-2:WORD_W-1])) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

	// Each level does pos += vel*sp and vel += acc*sv side by side. Levels pair
	// up into substeps: even level drifts and kicks (Euler: kick), odd level drifts.
	function automatic steps_t level_steps(input logic [2:0] lvl, input logic [1:0] mode,
		input logic [STEP_W-1:0] dt, input logic [DT_W-1:0] d1, input logic [DT_W-1:0] d2);
		steps_t          s;
		logic [DT_W-1:0] dtw;
		logic [DT_W-1:0] full;
		logic [1:0]      sub;
		logic            kick;
		dtw  = DT_W'(dt);
		full = '0;
		sub  = lvl[2:1];
		kick = !lvl[0];
		s    = '0;
		case (mode)
			MODE_VERLET: begin
				if (sub == 2'd0) full = dtw;
			end
			MODE_FOREST_RUTH: begin
				case (sub)
					2'd0:    full = d1;
					2'd1:    full = d2;
					2'd2:    full = d1;
					default: full = '0;
				endcase
			end
			default: begin
				// semi-implicit Euler (unused code too): kick, then full drift
				if (sub == 2'd0) begin
					if (kick) s.sv = dtw;
					else      s.sp = dtw;
				end
			end
		endcase
		if (mode == MODE_VERLET || mode == MODE_FOREST_RUTH) begin
			s.sp = {full[DT_W-1], full[DT_W-1:1]};
			s.sv = kick ? full : '0;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

[sv/symplectic_motion_integrator.sv]
// Top level of the symplectic motion integrator: config register, pipeline chain.
// Depends on smi_pkg, smi_step_gen, smi_mac_level, smi_skid and the macros header.
//
// Usage:
//  - Write integrator_mode over the APB port at address 0 while the block is
//    idle: 0 semi-implicit Euler, 1 Verlet, 2 Forest-Ruth, 3 as Euler.
//  - Input items (position, velocity, acceleration, step length) are taken on
//    in_valid && in_ready; results leave on out_valid && out_ready, in order.
//  - One item per cycle sustained while out_ready stays high. out_valid rises once
//    an item has passed fifteen register stages: two forming the substep lengths, six
//    update levels of two each (multiply, then add and saturate), one output register.
//    The six levels cover the deepest chain, three Forest-Ruth substeps of a
//    drift-kick and a dependent drift; shorter modes pass through with zero step.
//  - Reset clears the mode to 0 and empties the pipeline.
//  - When the receiver stalls, items close up behind the output register and a
//    skid entry; up to 16 items are held and in_ready drops only when all slots
//    are full. in_ready depends on registered state only.
`default_nettype none

`include "symplectic_motion_integrator_macros.svh"

module symplectic_motion_integrator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [smi_pkg::WORD_W-1:0] pos_x,
	input  wire logic signed [smi_pkg::WORD_W-1:0] pos_y,
	input  wire logic signed [smi_pkg::WORD_W-1:0] pos_z,
	input  wire logic signed [smi_pkg::WORD_W-1:0] vel_x,
	input  wire logic signed [smi_pkg::WORD_W-1:0] vel_y,
	input  wire logic signed [smi_pkg::WORD_W-1:0] vel_z,
	input  wire logic signed [smi_pkg::WORD_W-1:0] acc_x,
	input  wire logic signed [smi_pkg::WORD_W-1:0] acc_y,
	input  wire logic signed [smi_pkg::WORD_W-1:0] acc_z,
	input  wire logic        [smi_pkg::STEP_W-1:0] step_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [smi_pkg::WORD_W-1:0] new_pos_x,
	output logic signed [smi_pkg::WORD_W-1:0] new_pos_y,
	output logic signed [smi_pkg::WORD_W-1:0] new_pos_z,
	output logic signed [smi_pkg::WORD_W-1:0] new_vel_x,
	output logic signed [smi_pkg::WORD_W-1:0] new_vel_y,
	output logic signed [smi_pkg::WORD_W-1:0] new_vel_z
);

	logic [1:0]                     mode_q;
	logic [smi_pkg::FLIGHT_W-1:0]   in_flight_q;
	smi_pkg::body_t                 in_body;
	smi_pkg::body_t                 chain_body  [smi_pkg::LEVELS+1];
	logic                           chain_valid [smi_pkg::LEVELS+1];
	logic                           chain_ready [smi_pkg::LEVELS+1];
	smi_pkg::res_t                  res_in, res_out;
	logic                           skid_full, acc_in, acc_out;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= smi_pkg::MODE_EULER;
		end else if (psel && penable && pwrite && pready && paddr[2] == smi_pkg::REG_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == smi_pkg::REG_MODE) prdata = {30'd0, mode_q};
	end

	// item entry
	always_comb begin
		in_body        = '0;
		in_body.pos[0] = pos_x;
		in_body.pos[1] = pos_y;
		in_body.pos[2] = pos_z;
		in_body.vel[0] = vel_x;
		in_body.vel[1] = vel_y;
		in_body.vel[2] = vel_z;
		in_body.acc[0] = acc_x;
		in_body.acc[1] = acc_y;
		in_body.acc[2] = acc_z;
		in_body.mode   = mode_q;
		in_body.dt     = step_length;
	end

	smi_step_gen u_step_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_body   (in_body),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_body  (chain_body[0])
	);

	for (genvar g = 0; g < smi_pkg::LEVELS; g++) begin : g_level
		smi_mac_level u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.lvl       (3'(g)),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_body   (chain_body[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_body  (chain_body[g+1])
		);
	end

	assign res_in.pos = chain_body[smi_pkg::LEVELS].pos;
	assign res_in.vel = chain_body[smi_pkg::LEVELS].vel;

	smi_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (chain_valid[smi_pkg::LEVELS]),
		.up_ready  (chain_ready[smi_pkg::LEVELS]),
		.up_data   (res_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out),
		.full      (skid_full)
	);

	assign new_pos_x = res_out.pos[0];
	assign new_pos_y = res_out.pos[1];
	assign new_pos_z = res_out.pos[2];
	assign new_vel_x = res_out.vel[0];
	assign new_vel_y = res_out.vel[1];
	assign new_vel_z = res_out.vel[2];

	// items inside the block, for checking only
	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else begin
			in_flight_q <= in_flight_q + smi_pkg::FLIGHT_W'(acc_in)
				- smi_pkg::FLIGHT_W'(acc_out);
		end
	end

	`SMI_ASSERT_IMP(a_no_overfill, 1'b1, in_flight_q <= smi_pkg::FLIGHT_W'(smi_pkg::CAP), "more items held than slots")
	`SMI_ASSERT_IMP(a_skid_behind_out, skid_full, out_valid, "skid entry filled while output register empty")
	`SMI_ASSERT_NXT(a_no_invented_item, in_flight_q == '0 && !acc_in, !out_valid, "result shown with no item in flight")

endmodule

`default_nettype wire

[sv/smi_step_gen.sv]
// Entry stages: forms the Forest-Ruth substep lengths from the step length.
// Depends on smi_pkg.
`default_nettype none

module smi_step_gen (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire smi_pkg::body_t in_body,
	output logic               out_valid,
	input  wire logic          out_ready,
	output smi_pkg::body_t     out_body
);

	logic                          v_s1, v_s2, en_s1, en_s2;
	smi_pkg::body_t                body_s1, body_s2, body_nx;
	logic [smi_pkg::MP_W-1:0]      m1_s1, m2_s1;
	logic signed [smi_pkg::MP_W:0] neg2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_comb begin
		neg2       = -$signed({1'b0, m2_s1});
		body_nx    = body_s1;
		body_nx.d1 = smi_pkg::DT_W'(m1_s1 >> smi_pkg::COEF_FRAC);
		body_nx.d2 = smi_pkg::DT_W'(neg2 >>> smi_pkg::COEF_FRAC);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			body_s1 <= in_body;
			m1_s1   <= smi_pkg::MP_W'(in_body.dt) * smi_pkg::MP_W'(smi_pkg::FR_OUTER);
			m2_s1   <= smi_pkg::MP_W'(in_body.dt) * smi_pkg::MP_W'(smi_pkg::FR_INNER);
		end
		if (en_s2) body_s2 <= body_nx;
	end

	assign out_valid = v_s2;
	assign out_body  = body_s2;

endmodule

`default_nettype wire

[sv/smi_mac_level.sv]
// One update level: multiply stage, then shift, add and saturate stage.
// Depends on smi_pkg; the top level chains six of these.
`default_nettype none

module smi_mac_level (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [2:0]     lvl,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire smi_pkg::body_t in_body,
	output logic                out_valid,
	input  wire logic           out_ready,
	output smi_pkg::body_t      out_body
);

	logic                                       v_s1, v_s2, en_s1, en_s2;
	smi_pkg::steps_t                            steps;
	smi_pkg::body_t                             body_s1, body_s2, body_nx;
	logic signed [2:0][smi_pkg::PROD_W-1:0]     pp_s1, pv_s1;
	logic signed [2:0][smi_pkg::PROD_W-1:0]     pp_nx, pv_nx;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_comb begin
		steps = smi_pkg::level_steps(lvl, in_body.mode, in_body.dt, in_body.d1, in_body.d2);
		for (int i = 0; i < 3; i++) begin
			// both updates read the velocity entering this level
			pp_nx[i] = $signed(in_body.vel[i]) * $signed(steps.sp);
			pv_nx[i] = $signed(in_body.acc[i]) * $signed(steps.sv);
		end
	end

	always_comb begin
		body_nx = body_s1;
		for (int i = 0; i < 3; i++) begin
			body_nx.pos[i] = smi_pkg::sat_add($signed(body_s1.pos[i]), pp_s1[i]);
			body_nx.vel[i] = smi_pkg::sat_add($signed(body_s1.vel[i]), pv_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			body_s1 <= in_body;
			pp_s1   <= pp_nx;
			pv_s1   <= pv_nx;
		end
		if (en_s2) body_s2 <= body_nx;
	end

	assign out_valid = v_s2;
	assign out_body  = body_s2;

endmodule

`default_nettype wire

[sv/smi_skid.sv]
// Output register with a skid entry; keeps in_ready free of out_ready.
// Depends on smi_pkg.
`default_nettype none

module smi_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire smi_pkg::res_t up_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output smi_pkg::res_t      out_data,
	output logic               full
);

	logic          out_valid_q, skid_valid_q, pop, push, load;
	smi_pkg::res_t out_data_q, skid_data_q;

	assign up_ready = !skid_valid_q;
	assign pop      = out_valid_q && out_ready;
	assign push     = up_valid && up_ready;
	assign load     = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_data_q <= skid_valid_q ? skid_data_q : up_data;
		else if (push) skid_data_q <= up_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign full      = skid_valid_q;

endmodule

`default_nettype wire
